FILE: hdl/tree_bitmap_id_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tree bitmap identifier allocator
// Two property forms (same-cycle and next-cycle implication) that report
// through $error. Defining ASSERT_OFF turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef TREE_BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH
`define TREE_BITMAP_ID_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define TBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define TBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/tba_pkg.sv
// ----------------------------------------------------------------------------
// Tree bitmap identifier allocator package
// Tree dimensions, transaction payload types and the interface between the
// sequencer and the tree row store.
// ----------------------------------------------------------------------------
package tba_pkg;

    // Tree depth: the pool holds 2^LEVELS identifiers.
    localparam int LEVELS = 5;

    // Width of the identifier fields in the transaction payloads.
    localparam int ID_W = 5;

    // Each inner node owns one row holding the full bits of its two children.
    localparam int ROW_COUNT = (1 << LEVELS) - 1;
    localparam int ADDR_W    = LEVELS;

    // Level counter width.
    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Request transaction payload.
    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] id;
    } req_item_t;

    // Response transaction payload.
    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            success;
        logic            pool_full;
    } rsp_item_t;

    // Request modes.
    localparam logic MODE_TAKE   = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    // Read and write requests toward the tree row store.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [1:0]        wr_data;
    } mem_req_t;

    // Low LEVELS bits of a payload identifier, zero extended if the tree is wider.
    function automatic logic [LEVELS-1:0] to_leaf(input logic [ID_W-1:0] id);
        logic [LEVELS+ID_W-1:0] wide;
        wide = {{LEVELS{1'b0}}, id};
        return wide[LEVELS-1:0];
    endfunction

    // Leaf number cut or extended to the payload identifier width.
    function automatic logic [ID_W-1:0] to_id(input logic [LEVELS-1:0] leaf);
        logic [LEVELS+ID_W-1:0] wide;
        wide = {{ID_W{1'b0}}, leaf};
        return wide[ID_W-1:0];
    endfunction

endpackage

FILE: hdl/tree_bitmap_id_allocator_top.sv
// One transaction at a time: a new request is accepted only in the idle state, after the
// walk through the tree row store, one level per cycle down and one level per cycle back
// up, has finished (a take from a full pool skips the walk); a stalled response holds the
// next one in the finish state.
// Reset (rst_n, asynchronous, active low) frees every identifier at once.
// ----------------------------------------------------------------------------
// Tree bitmap identifier allocator
// Grants the lowest free identifier on a take and frees the named identifier on
// a return, keeping a full bit per node of a binary tree in a row store.
// ----------------------------------------------------------------------------
`include "tree_bitmap_id_allocator_top_assert.svh"

module tree_bitmap_id_allocator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  tba_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output tba_pkg::rsp_item_t rsp
);
    import tba_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DOWN = 4'b0010,
        ST_UP   = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // Control state.
    state_t           state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             root_full_reg, root_full_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Working payload.
    logic              mode_reg, mode_next;
    logic              succ_reg, succ_next;
    logic [LEVELS-1:0] ret_reg, ret_next;
    logic [LEVELS-1:0] leaf_reg, leaf_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic              val_reg, val_next;
    logic [1:0]        rows_reg [LEVELS];
    logic [ADDR_W-1:0] addr_reg [LEVELS];
    logic              dir_reg  [LEVELS];
    rsp_item_t         rsp_reg, rsp_next;

    mem_req_t          mem_req;
    logic [1:0]        rd_row;

    logic              accept;
    logic              load_rsp;
    logic              dir;
    logic [ADDR_W:0]   child_wide;
    logic [1:0]        new_row;
    logic              last_lvl;

    // Tree row store.
    tba_tree_mem u_tree_mem (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mem_req),
        .rd_row (rd_row)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign load_rsp  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);
    assign last_lvl  = (lvl_reg == LVL_W'(LEVELS - 1));

    // Branch choice on the way down: the return path follows the identifier,
    // most significant bit first; a take goes right only when the left is full.
    assign dir = (mode_reg == MODE_RETURN) ? ret_reg[LEVELS-1] : rd_row[0];
    assign child_wide = {node_reg, 1'b0} + (ADDR_W + 1)'(1) + (ADDR_W + 1)'(dir);

    // Row rewrite on the way up: update the bit of the child on the path.
    assign new_row = dir_reg[lvl_reg] ? {val_reg, rows_reg[lvl_reg][0]}
                                      : {rows_reg[lvl_reg][1], val_reg};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        root_full_next = root_full_reg;
        rsp_valid_next = rsp_valid_reg;
        mode_next      = mode_reg;
        succ_next      = succ_reg;
        ret_next       = ret_reg;
        leaf_next      = leaf_reg;
        node_next      = node_reg;
        val_next       = val_reg;
        rsp_next       = rsp_reg;
        mem_req        = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    ret_next  = to_leaf(req.id);
                    leaf_next = '0;
                    node_next = '0;
                    lvl_next  = '0;
                    if ((req.mode == MODE_TAKE) && root_full_reg)
                    begin
                        succ_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        succ_next       = 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_next      = ST_DOWN;
                    end
                end
            end
            ST_DOWN:
            begin
                leaf_next = (leaf_reg << 1) | LEVELS'(dir);
                ret_next  = ret_reg << 1;
                node_next = child_wide[ADDR_W-1:0];
                if (last_lvl)
                begin
                    val_next   = (mode_reg == MODE_TAKE);
                    state_next = ST_UP;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = child_wide[ADDR_W-1:0];
                    lvl_next        = lvl_reg + LVL_W'(1);
                end
            end
            ST_UP:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = addr_reg[lvl_reg];
                mem_req.wr_data = new_row;
                val_next        = &new_row;
                if (lvl_reg == '0)
                begin
                    root_full_next = &new_row;
                    state_next     = ST_FIN;
                end
                else
                begin
                    lvl_next = lvl_reg - LVL_W'(1);
                end
            end
            ST_FIN:
            begin
                if (load_rsp)
                begin
                    rsp_next.granted_id = ((mode_reg == MODE_TAKE) && succ_reg)
                                          ? to_id(leaf_reg) : '0;
                    rsp_next.success    = succ_reg;
                    rsp_next.pool_full  = root_full_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            root_full_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            root_full_reg <= root_full_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers; the path rows are captured on the way down.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        succ_reg <= succ_next;
        ret_reg  <= ret_next;
        leaf_reg <= leaf_next;
        node_reg <= node_next;
        val_reg  <= val_next;
        rsp_reg  <= rsp_next;
        if (state_reg == ST_DOWN)
        begin
            rows_reg[lvl_reg] <= rd_row;
            addr_reg[lvl_reg] <= node_reg;
            dir_reg[lvl_reg]  <= dir;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TBA_ASSERT_NOW(a_fail_only_when_full, clk, rst_n,
        (state_reg == ST_FIN) && !succ_reg,
        root_full_reg && (mode_reg == MODE_TAKE),
        "take failed on a pool that is not full")
    `TBA_ASSERT_NEXT(a_up_ends_in_fin, clk, rst_n,
        (state_reg == ST_UP) && (lvl_reg == '0),
        state_reg == ST_FIN,
        "update pass did not finish after the root row")
    `TBA_ASSERT_NOW(a_down_level_range, clk, rst_n,
        (state_reg == ST_DOWN) || (state_reg == ST_UP),
        lvl_reg <= LVL_W'(LEVELS - 1),
        "level counter out of range")

endmodule

FILE: hdl/tba_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 31
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Storage write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/tba_tree_mem.sv
// ----------------------------------------------------------------------------
// Tree row store
// Holds the full bits of all non-root nodes, one row per parent node. Valid
// bits cleared at reset make every row read as empty until it is written.
// ----------------------------------------------------------------------------
`include "tree_bitmap_id_allocator_top_assert.svh"

module tba_tree_mem (
    input  logic             clk,
    input  logic             rst_n,
    input  tba_pkg::mem_req_t req,
    output logic [1:0]       rd_row
);
    import tba_pkg::*;

    logic [ROW_COUNT-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [1:0]           ram_q;

    // Row storage.
    tba_ram #(
        .WIDTH (2),
        .DEPTH (ROW_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // A row becomes valid on its first write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // A row never written reads as both children free.
    assign rd_row = rd_valid_reg ? ram_q : 2'b00;

    `TBA_ASSERT_NOW(a_no_rd_wr_same_cycle, clk, rst_n, req.wr_en, !req.rd_en, "row store read and written in the same cycle")
    `TBA_ASSERT_NEXT(a_write_sets_valid, clk, rst_n, req.wr_en, valid_reg[$past(req.wr_addr)], "written row not marked valid")
    `TBA_ASSERT_NEXT(a_unwritten_reads_empty, clk, rst_n, req.rd_en && !valid_reg[req.rd_addr], rd_row == 2'b00, "unwritten row did not read as empty")

endmodule

FILE: test/tree_bitmap_id_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// Tree bitmap identifier allocator testbench
// Drives take and return transactions through bursty request traffic and a
// stalling response side. A scoreboard keeps its own copy of the tree of full
// bits, predicts every response and checks each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tree_bitmap_id_allocator_top_tb;

    import tba_pkg::*;

    localparam int LEAF_COUNT  = 1 << LEVELS;
    localparam int NODE_COUNT  = (2 << LEVELS) - 1;
    localparam int FIRST_LEAF  = LEAF_COUNT - 1;
    localparam int LATENCY     = 2 * LEVELS + 2;
    localparam int ITEM_TARGET = 1450;
    localparam int HOLD_CYCLES = 300;

    // Shapes of the random traffic phases.
    typedef enum logic [1:0] {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_t;

    // One queued request, optionally held back until the scoreboard is empty.
    typedef struct {
        req_item_t item;
        bit        wait_idle;
    } pending_req_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    pending_req_t     pending_q[$];
    rsp_item_t        grant_q[$];
    logic [NODE_COUNT-1:0] full_tree = '0;

    // Driver pacing.
    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;

    // Receiver pacing.
    logic [15:0] ready_pattern = 16'hffff;
    int unsigned pattern_left  = 0;
    int unsigned hold_left     = 0;
    int unsigned holds_done    = 0;

    // Statistics and error tracking.
    int unsigned sent_cnt        = 0;
    int unsigned checked_cnt     = 0;
    int unsigned take_cnt        = 0;
    int unsigned return_cnt      = 0;
    int unsigned full_take_cnt   = 0;
    int unsigned free_return_cnt = 0;
    int unsigned pool_full_cnt   = 0;
    int unsigned error_cnt       = 0;

    tree_bitmap_id_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Recompute the full bits along the path from node n up to the root.
    function automatic void refresh_path(input int unsigned n);
        int unsigned node;
        int unsigned parent;
        node = n;
        while (node > 0)
        begin
            parent = (node - 1) >> 1;
            full_tree[parent] = full_tree[2 * parent + 1] & full_tree[2 * parent + 2];
            node = parent;
        end
    endfunction

    // Apply one request to the shadow tree and return the expected response.
    function automatic rsp_item_t predict_grant(input req_item_t r);
        rsp_item_t   exp_rsp;
        int unsigned node;
        int unsigned lvl;
        int unsigned leaf;
        exp_rsp = '0;
        exp_rsp.success = 1'b1;
        if (r.mode == MODE_TAKE)
        begin
            take_cnt++;
            if (full_tree[0])
            begin
                exp_rsp.success = 1'b0;
                full_take_cnt++;
            end
            else
            begin
                node = 0;
                for (lvl = 0; lvl < LEVELS; lvl++)
                    node = full_tree[2 * node + 1] ? 2 * node + 2 : 2 * node + 1;
                full_tree[node] = 1'b1;
                refresh_path(node);
                leaf = node - FIRST_LEAF;
                exp_rsp.granted_id = leaf[ID_W-1:0];
            end
        end
        else
        begin
            return_cnt++;
            leaf = r.id % LEAF_COUNT;
            node = FIRST_LEAF + leaf;
            if (!full_tree[node])
                free_return_cnt++;
            full_tree[node] = 1'b0;
            refresh_path(node);
        end
        exp_rsp.pool_full = full_tree[0];
        if (exp_rsp.pool_full)
            pool_full_cnt++;
        return exp_rsp;
    endfunction

    // Count a failure and describe it while the report budget lasts.
    function automatic void note_mismatch(input string what, input int unsigned exp_val,
                                          input int unsigned act_val);
        error_cnt++;
        if (error_cnt <= 10)
            $display("%0t: mismatch on %s after %0d responses: expected %0h, got %0h",
                     $realtime, what, checked_cnt, exp_val, act_val);
    endfunction

    // Queue one request for the driver.
    function automatic void queue_req(input logic mode, input logic [ID_W-1:0] id,
                                      input bit wait_idle);
        pending_req_t entry;
        entry.item.mode = mode;
        entry.item.id   = id;
        entry.wait_idle = wait_idle;
        pending_q.push_back(entry);
    endfunction

    // Request driver: bursts of transactions separated by random gaps. A
    // transaction is predicted at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        logic         next_valid;
        pending_req_t entry;
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            next_valid = req_valid;
            if (req_valid && req_ready)
            begin
                grant_q.push_back(predict_grant(req));
                sent_cnt++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].wait_idle && grant_q.size() > 0))
                begin
                    entry = pending_q.pop_front();
                    req <= entry.item;
                    next_valid = 1'b1;
                    if (burst_left > 0)
                    begin
                        burst_left <= burst_left - 1;
                    end
                    else
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
            req_valid <= next_valid;
        end
    end

    // Response side: stalls on a rotating random pattern, and twice holds off
    // for a long stretch so that the block backs up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready     <= 1'b0;
            ready_pattern <= 16'hffff;
            pattern_left  <= 0;
            hold_left     <= 0;
            holds_done    <= 0;
        end
        else if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && checked_cnt >= 400) ||
                 (holds_done == 1 && checked_cnt >= 1000))
        begin
            rsp_ready  <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else if (pattern_left == 0)
        begin
            case ($urandom_range(0, 2))
                0:       ready_pattern <= 16'hffff;
                1:       ready_pattern <= 16'($urandom_range(0, 16'hffff)) | 16'h0101;
                default: ready_pattern <= (16'($urandom_range(0, 16'hffff)) & 16'h1111)
                                          | 16'h0001;
            endcase
            pattern_left <= 16 * $urandom_range(1, 8);
            rsp_ready    <= 1'b1;
        end
        else
        begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
            pattern_left  <= pattern_left - 1;
            rsp_ready     <= ready_pattern[15];
        end
    end

    // Response monitor: compare every accepted response with the oldest
    // prediction.
    always @(posedge clk)
    begin
        rsp_item_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (grant_q.size() == 0)
            begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("%0t: response with nothing expected: granted_id %0h success %0b",
                             $realtime, rsp.granted_id, rsp.success);
            end
            else
            begin
                exp_rsp = grant_q.pop_front();
                if (rsp.granted_id !== exp_rsp.granted_id)
                    note_mismatch("granted_id", 32'(exp_rsp.granted_id), 32'(rsp.granted_id));
                if (rsp.success !== exp_rsp.success)
                    note_mismatch("success", 32'(exp_rsp.success), 32'(rsp.success));
                if (rsp.pool_full !== exp_rsp.pool_full)
                    note_mismatch("pool_full", 32'(exp_rsp.pool_full), 32'(rsp.pool_full));
            end
            checked_cnt++;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned queued;
        int unsigned span;
        int unsigned k;
        int unsigned take_pct;
        int unsigned next_pause;
        phase_t      phase;

        // Directed opening: first grants, reuse of the lowest freed identifier,
        // returns of free identifiers, both extremes of the id field, and an id
        // on a take that must be ignored.
        queue_req(MODE_TAKE,   5'd0,  1'b0);
        queue_req(MODE_TAKE,   5'd31, 1'b0);
        queue_req(MODE_TAKE,   5'd0,  1'b0);
        queue_req(MODE_RETURN, 5'd1,  1'b0);
        queue_req(MODE_TAKE,   5'd0,  1'b0);
        queue_req(MODE_RETURN, 5'd1,  1'b0);
        queue_req(MODE_RETURN, 5'd1,  1'b0);
        queue_req(MODE_RETURN, 5'd31, 1'b0);
        queue_req(MODE_RETURN, 5'd16, 1'b0);
        queue_req(MODE_RETURN, 5'd0,  1'b0);
        queue_req(MODE_TAKE,   5'd21, 1'b0);
        queue_req(MODE_TAKE,   5'd10, 1'b0);
        queue_req(MODE_TAKE,   5'd0,  1'b0);
        queue_req(MODE_RETURN, 5'd2,  1'b0);
        queue_req(MODE_RETURN, 5'd0,  1'b0);
        queue_req(MODE_RETURN, 5'd3,  1'b0);
        queue_req(MODE_TAKE,   5'd0,  1'b0);
        queue_req(MODE_RETURN, 5'd0,  1'b0);
        queued = pending_q.size();

        // Random phases: filling drives the pool to full and past it, draining
        // empties it, mixed traffic wanders in between. Every so often the
        // sender waits until all responses are back.
        next_pause = queued;
        phase = PH_FILL;
        while (queued < ITEM_TARGET)
        begin
            span = $urandom_range(20, 80);
            case (phase)
                PH_FILL:  take_pct = 90;
                PH_DRAIN: take_pct = 15;
                default:  take_pct = 50;
            endcase
            for (k = 0; k < span && queued < ITEM_TARGET; k++)
            begin
                queue_req(($urandom_range(1, 100) <= take_pct) ? MODE_TAKE : MODE_RETURN,
                          ID_W'($urandom_range(0, 31)), queued >= next_pause);
                if (queued >= next_pause)
                    next_pause = queued + $urandom_range(200, 400);
                queued++;
            end
            case ($urandom_range(0, 2))
                0:       phase = PH_FILL;
                1:       phase = PH_DRAIN;
                default: phase = PH_MIXED;
            endcase
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the request queue to drain and every response to come back.
        while (pending_q.size() > 0 || req_valid || grant_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Covered %0d requests: %0d takes (%0d on a full pool), %0d returns (%0d free).",
                 sent_cnt, take_cnt, full_take_cnt, return_cnt, free_return_cnt);
        $display("Checked %0d responses, %0d reporting a full pool, %0d errors.",
                 checked_cnt, pool_full_cnt, error_cnt);
        if (error_cnt == 0 && grant_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/tba_pkg.sv
hdl/tba_ram.sv
hdl/tba_tree_mem.sv
hdl/tree_bitmap_id_allocator_top.sv
test/tree_bitmap_id_allocator_top_tb.sv
